// ===== rtl/nirfd_pkg.sv =====
// Shared types, constants and the window compare for the NEC IR frame decoder.
package nirfd_pkg;

   localparam int TICK_W      = 15;
   localparam int COUNT_W     = 7;
   localparam int CSR_IDX_W   = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] FRAME_LEN  = 7'd34;
   localparam logic [COUNT_W-1:0] REPEAT_LEN = 7'd2;
   localparam logic [COUNT_W-1:0] DATA_LAST  = 7'd32;  // last data symbol index
   localparam int                 HALF_BITS  = 16;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MARGIN       = 4'd0,
      CSR_LEAD_MARK    = 4'd1,
      CSR_LEAD_SPACE   = 4'd2,
      CSR_REPEAT_SPACE = 4'd3,
      CSR_ZERO_MARK    = 4'd4,
      CSR_ZERO_SPACE   = 4'd5,
      CSR_ONE_MARK     = 4'd6,
      CSR_ONE_SPACE    = 4'd7
   } csr_index_type;

   localparam logic [TICK_W-1:0] RST_MARGIN       = 15'd200;
   localparam logic [TICK_W-1:0] RST_LEAD_MARK    = 15'd9000;
   localparam logic [TICK_W-1:0] RST_LEAD_SPACE   = 15'd4500;
   localparam logic [TICK_W-1:0] RST_REPEAT_SPACE = 15'd2250;
   localparam logic [TICK_W-1:0] RST_ZERO_MARK    = 15'd560;
   localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 15'd560;
   localparam logic [TICK_W-1:0] RST_ONE_MARK     = 15'd560;
   localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 15'd1690;

   typedef enum logic [1:0] {
      KIND_FRAME     = 2'd0,
      KIND_REPEAT    = 2'd1,
      KIND_MALFORMED = 2'd2,
      KIND_UNKNOWN   = 2'd3
   } frame_kind_type;

   // classified symbol, front to back
   typedef struct packed {
      logic lead;
      logic rep;
      logic one;
      logic zero;
      logic last;
   } sym_class_type;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic               pop;
      logic [COUNT_W-1:0] sym_count;
   } back_status_type;

   // strict window n - m < d < n + m, no wrap
   function automatic logic in_window(input logic [TICK_W-1:0] d,
                                      input logic [TICK_W-1:0] n,
                                      input logic [TICK_W-1:0] m);
      logic [TICK_W:0] hi;
      logic [TICK_W:0] dm;
      hi = {1'b0, n} + {1'b0, m};
      dm = {1'b0, d} + {1'b0, m};
      return ({1'b0, d} < hi) && (dm > {1'b0, n});
   endfunction

endpackage

// ===== rtl/nirfd_front.sv =====
// Front end: timing registers, symbol accept and window classification.
module nirfd_front import nirfd_pkg::*; #(
   parameter int REPEAT_MARK_TICKS = 9000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TICK_W-1:0]    mark_ticks,
   input  logic [TICK_W-1:0]    space_ticks,
   input  logic                 end_of_capture,
   input  queue_status_type     q_status,
   output logic                 push,
   output sym_class_type        push_data
);

   localparam logic [TICK_W-1:0] REP_MARK = TICK_W'(REPEAT_MARK_TICKS);

   logic [TICK_W-1:0] margin_ff, lead_mark_ff, lead_space_ff, rep_space_ff;
   logic [TICK_W-1:0] zero_mark_ff, zero_space_ff, one_mark_ff, one_space_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff     <= RST_MARGIN;
         lead_mark_ff  <= RST_LEAD_MARK;
         lead_space_ff <= RST_LEAD_SPACE;
         rep_space_ff  <= RST_REPEAT_SPACE;
         zero_mark_ff  <= RST_ZERO_MARK;
         zero_space_ff <= RST_ZERO_SPACE;
         one_mark_ff   <= RST_ONE_MARK;
         one_space_ff  <= RST_ONE_SPACE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MARGIN:       margin_ff     <= csr_wdata;
            CSR_LEAD_MARK:    lead_mark_ff  <= csr_wdata;
            CSR_LEAD_SPACE:   lead_space_ff <= csr_wdata;
            CSR_REPEAT_SPACE: rep_space_ff  <= csr_wdata;
            CSR_ZERO_MARK:    zero_mark_ff  <= csr_wdata;
            CSR_ZERO_SPACE:   zero_space_ff <= csr_wdata;
            CSR_ONE_MARK:     one_mark_ff   <= csr_wdata;
            CSR_ONE_SPACE:    one_space_ff  <= csr_wdata;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_data.lead = in_window(mark_ticks, lead_mark_ff, margin_ff)
                    && in_window(space_ticks, lead_space_ff, margin_ff);
      push_data.rep  = in_window(mark_ticks, REP_MARK, margin_ff)
                    && in_window(space_ticks, rep_space_ff, margin_ff);
      push_data.one  = in_window(mark_ticks, one_mark_ff, margin_ff)
                    && in_window(space_ticks, one_space_ff, margin_ff);
      push_data.zero = in_window(mark_ticks, zero_mark_ff, margin_ff)
                    && in_window(space_ticks, zero_space_ff, margin_ff);
      push_data.last = end_of_capture;
   end

endmodule

// ===== rtl/nirfd_queue.sv =====
// Short FIFO of classified symbols between front and back.
module nirfd_queue import nirfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sym_class_type    push_data,
   input  logic             pop,
   output sym_class_type    head,
   output queue_status_type status
);

   sym_class_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

// ===== rtl/nirfd_back.sv =====
// Back end: per-capture state, frame classification and result register.
module nirfd_back import nirfd_pkg::*; #(
   parameter int MAX_SYMBOLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  sym_class_type    head,
   output back_status_type  status,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       frame_kind,
   output logic [15:0]      address_out,
   output logic [15:0]      command_out,
   output logic [7:0]       key_value
);

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SYMBOLS);

   logic [COUNT_W-1:0] count_ff, count_in, count_next;
   logic               lead_ff, lead_in;
   logic               rep_ff, rep_in;
   logic               bits_ok_ff, bits_ok_in;
   logic [31:0]        shift_ff, shift_in;
   logic [15:0]        addr_ff, addr_in;
   logic [15:0]        cmd_ff, cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   frame_kind_type     kind_ff, kind_in;
   logic [4:0]         bit_idx;
   logic               pop;

   // a last symbol needs room in the result register
   assign pop     = q_status.valid && (!head.last || !rsp_valid_ff || rsp_tready);
   assign bit_idx = 5'(count_ff - 7'd1);

   always_comb begin
      count_in     = count_ff;
      lead_in      = lead_ff;
      rep_in       = rep_ff;
      bits_ok_in   = bits_ok_ff;
      shift_in     = shift_ff;
      addr_in      = addr_ff;
      cmd_in       = cmd_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      count_next   = (count_ff < MAX_CNT) ? count_ff + 7'd1 : count_ff;
      if (pop) begin
         if (count_ff == '0) begin
            lead_in = head.lead;
            rep_in  = head.rep;
         end else if (count_ff <= DATA_LAST) begin
            if (head.one) begin
               shift_in = shift_ff | (32'd1 << bit_idx);
            end else if (!head.zero) begin
               bits_ok_in = 1'b0;
            end
         end
         count_in = count_next;
         if (head.last) begin
            priority if (count_next == FRAME_LEN) begin
               if (lead_in && bits_ok_in) begin
                  addr_in = shift_in[HALF_BITS-1:0];
                  cmd_in  = shift_in[2*HALF_BITS-1:HALF_BITS];
                  kind_in = KIND_FRAME;
               end else begin
                  kind_in = KIND_MALFORMED;
               end
            end else if (count_next == REPEAT_LEN) begin
               kind_in = rep_in ? KIND_REPEAT : KIND_MALFORMED;
            end else begin
               kind_in = KIND_UNKNOWN;
            end
            rsp_valid_in = 1'b1;
            count_in     = '0;
            lead_in      = 1'b0;
            rep_in       = 1'b0;
            bits_ok_in   = 1'b1;
            shift_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lead_ff      <= 1'b0;
         rep_ff       <= 1'b0;
         bits_ok_ff   <= 1'b1;
         shift_ff     <= '0;
         addr_ff      <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lead_ff      <= lead_in;
         rep_ff       <= rep_in;
         bits_ok_ff   <= bits_ok_in;
         shift_ff     <= shift_in;
         addr_ff      <= addr_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign status.pop       = pop;
   assign status.sym_count = count_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign frame_kind  = kind_ff;
   assign address_out = addr_ff;
   assign command_out = cmd_ff;
   assign key_value   = cmd_ff[15:8];

endmodule

// ===== rtl/nec_ir_frame_decoder_core.sv =====
// Top level of the NEC IR frame decoder: front, symbol queue and back.
//
// Channel   Dir  Bus           Contents (lowest bit first)
// req_      in   tdata[31:0]   mark_ticks[14:0], space_ticks[29:15], zero pad
//                tlast         end_of_capture
// rsp_      out  tdata[39:0]   address_out[15:0], command_out[31:16], key_value[39:32]
//                tuser[1:0]    frame_kind
// csr_      in   we/index/wdata  8 timing registers, 15 bits each
//
// One symbol per cycle is taken while the queue has room; the window compares
// are combinational logic ahead of a 4-deep queue, and the back end retires
// one queued symbol a cycle unless a last symbol waits on an unread result.
// A last symbol passes the queue, then the result register; symbols ahead go first.
// Reset is synchronous: timing registers go to their nominal values, the
// queue empties and the per-capture state, stored address and command clear.
// req_tready falls only when the queue is full; the back end stalls on a
// last symbol alone, while an unread result holds the output register.
module nec_ir_frame_decoder_core import nirfd_pkg::*; #(
   parameter int MAX_SYMBOLS       = 64,
   parameter int REPEAT_MARK_TICKS = 9000
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   // symbol input
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // mark_ticks, space_ticks, pad
   input  logic                 req_tlast,
   // result output
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // address_out, command_out, key_value
   output logic [1:0]           rsp_tuser    // frame_kind
);

   logic             push;
   sym_class_type    push_data;
   sym_class_type    head;
   queue_status_type q_status;
   back_status_type  b_status;
   logic [15:0]      address_out;
   logic [15:0]      command_out;
   logic [7:0]       key_value;

   nirfd_front #(
      .REPEAT_MARK_TICKS (REPEAT_MARK_TICKS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .mark_ticks     (req_tdata[14:0]),
      .space_ticks    (req_tdata[29:15]),
      .end_of_capture (req_tlast),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   nirfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (b_status.pop),
      .head      (head),
      .status    (q_status)
   );

   nirfd_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head        (head),
      .status      (b_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .frame_kind  (rsp_tuser),
      .address_out (address_out),
      .command_out (command_out),
      .key_value   (key_value)
   );

   assign rsp_tdata = {key_value, command_out, address_out};

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("symbol queue over depth");

   // a held result is never overwritten by a new last symbol
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(b_status.pop && head.last && rsp_tvalid && !rsp_tready))
      else $error("result overwritten while stalled");

   // symbol count saturates
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      b_status.sym_count <= COUNT_W'(MAX_SYMBOLS))
      else $error("symbol count past saturation");

   // a transfer into a full queue cannot happen
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into full queue");

endmodule

// ===== tb/nec_ir_frame_decoder_core_tb.sv =====
// Self-checking testbench for the NEC IR frame decoder core.
module nec_ir_frame_decoder_core_tb;
   import nirfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SYMBOL_CAP  = 64;
   localparam int REPEAT_MARK = 9000;
   localparam int TICK_MAX    = 32767;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 325;     // about 1950 symbols over the run
   localparam int CYCLE_LIMIT = 600000;

   // index past the register file, the block drops such writes
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 4'd15;

   typedef struct {
      frame_kind_type kind;
      logic [15:0]    address;
      logic [15:0]    command;
      logic [7:0]     key;
   } frame_result_type;

   // Decoder shadow: timing registers, per-capture state, stored frame and
   // the results still owed by the block.
   class frame_scoreboard;
      logic [TICK_W-1:0] timing [8];
      int unsigned       sym_count;
      bit                lead_ok;
      bit                repeat_ok;
      bit                bits_ok;
      logic [31:0]       shift_bits;
      logic [15:0]       saved_address;
      logic [15:0]       saved_command;
      frame_result_type  expected_frames [$];
      int                errors;

      function new();
         timing[CSR_MARGIN]       = RST_MARGIN;
         timing[CSR_LEAD_MARK]    = RST_LEAD_MARK;
         timing[CSR_LEAD_SPACE]   = RST_LEAD_SPACE;
         timing[CSR_REPEAT_SPACE] = RST_REPEAT_SPACE;
         timing[CSR_ZERO_MARK]    = RST_ZERO_MARK;
         timing[CSR_ZERO_SPACE]   = RST_ZERO_SPACE;
         timing[CSR_ONE_MARK]     = RST_ONE_MARK;
         timing[CSR_ONE_SPACE]    = RST_ONE_SPACE;
         saved_address = '0;
         saved_command = '0;
         errors = 0;
         clear_capture();
      endfunction

      function void clear_capture();
         sym_count  = 0;
         lead_ok    = 1'b0;
         repeat_ok  = 1'b0;
         bits_ok    = 1'b1;
         shift_bits = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
         if (idx <= CSR_ONE_SPACE)
            timing[idx] = val;
      endfunction

      // strict window, plain integers so nothing wraps
      function bit near_nominal(int d, int n);
         int m;
         m = timing[CSR_MARGIN];
         return (d < n + m) && (d + m > n);
      endfunction

      function bit pair_ok(int mk, int sp, int n_mk, int n_sp);
         return near_nominal(mk, n_mk) && near_nominal(sp, n_sp);
      endfunction

      function void note_symbol(logic [TICK_W-1:0] mk, logic [TICK_W-1:0] sp, logic last);
         frame_result_type res;
         if (sym_count == 0) begin
            lead_ok   = pair_ok(mk, sp, timing[CSR_LEAD_MARK], timing[CSR_LEAD_SPACE]);
            repeat_ok = pair_ok(mk, sp, REPEAT_MARK, timing[CSR_REPEAT_SPACE]);
         end else if (sym_count <= DATA_LAST) begin
            // a symbol inside both bit windows counts as a one
            if (pair_ok(mk, sp, timing[CSR_ONE_MARK], timing[CSR_ONE_SPACE]))
               shift_bits[sym_count-1] = 1'b1;
            else if (!pair_ok(mk, sp, timing[CSR_ZERO_MARK], timing[CSR_ZERO_SPACE]))
               bits_ok = 1'b0;
         end
         if (sym_count < SYMBOL_CAP)
            sym_count++;
         if (!last)
            return;
         if (sym_count == FRAME_LEN) begin
            if (lead_ok && bits_ok) begin
               saved_address = shift_bits[HALF_BITS-1:0];
               saved_command = shift_bits[2*HALF_BITS-1:HALF_BITS];
               res.kind = KIND_FRAME;
            end else begin
               res.kind = KIND_MALFORMED;
            end
         end else if (sym_count == REPEAT_LEN) begin
            res.kind = repeat_ok ? KIND_REPEAT : KIND_MALFORMED;
         end else begin
            res.kind = KIND_UNKNOWN;
         end
         res.address = saved_address;
         res.command = saved_command;
         res.key     = saved_command[15:8];
         expected_frames.push_back(res);
         clear_capture();
      endfunction

      function void check_frame(frame_result_type got);
         frame_result_type want;
         if (expected_frames.size() == 0) begin
            $error("result with none expected: frame_kind %0d", got.kind);
            errors++;
            return;
         end
         want = expected_frames.pop_front();
         if (got.kind !== want.kind) begin
            $error("frame_kind: expected %0d, actual %0d", want.kind, got.kind);
            errors++;
         end
         if (got.address !== want.address) begin
            $error("address_out: expected %h, actual %h", want.address, got.address);
            errors++;
         end
         if (got.command !== want.command) begin
            $error("command_out: expected %h, actual %h", want.command, got.command);
            errors++;
         end
         if (got.key !== want.key) begin
            $error("key_value: expected %h, actual %h", want.key, got.key);
            errors++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   // Block ports; every input starts at a known value.
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [TICK_W-1:0]    csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // mark_ticks, space_ticks, pad
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;         // address_out, command_out, key_value
   logic [1:0]           rsp_tuser;         // frame_kind

   frame_scoreboard sb;
   int send_idle_pct = 0;    // chance per cycle that the sender holds off
   int stall_pct     = 0;    // chance per cycle that the receiver stalls
   int symbols_sent  = 0;
   int cycle_count   = 0;

   nec_ir_frame_decoder_core #(
      .MAX_SYMBOLS      (SYMBOL_CAP),
      .REPEAT_MARK_TICKS(REPEAT_MARK)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver back-pressure, redrawn on each falling edge.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   // Both monitors on the rising edge, before the block's own updates land.
   // Results are checked ahead of noting a new symbol: a result can only stem
   // from symbols transferred on earlier edges.
   always @(posedge clock) begin
      frame_result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = frame_kind_type'(rsp_tuser);
            got.address = rsp_tdata[15:0];
            got.command = rsp_tdata[31:16];
            got.key     = rsp_tdata[39:32];
            sb.check_frame(got);
         end
         if (req_tvalid && req_tready)
            sb.note_symbol(req_tdata[14:0], req_tdata[29:15], req_tlast);
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Duration close to a nominal value. Clean draws stay inside the window
   // (edges excluded); otherwise half of them land just outside it.
   function automatic int tick_near(int n, bit clean);
      int m;
      int d;
      m = sb.timing[CSR_MARGIN];
      if (!clean && $urandom_range(1))
         d = $urandom_range(1) ? n + m : n - m;
      else if (m <= 1)
         d = n;
      else
         case ($urandom_range(3))
            0:       d = n + m - 1;
            1:       d = n - m + 1;
            default: d = n - m + 1 + int'($urandom_range(2 * m - 2));
         endcase
      if (d < 0)
         d = 0;
      if (d > TICK_MAX)
         d = TICK_MAX;
      return d;
   endfunction

   function automatic int noise_tick();
      case ($urandom_range(7))
         0:       return 0;
         1:       return TICK_MAX;
         default: return $urandom_range(TICK_MAX);
      endcase
   endfunction

   // One symbol transfer; entered and left just after a falling edge.
   task automatic send_symbol(int mk, int sp, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, sp[TICK_W-1:0], mk[TICK_W-1:0]};
      req_tlast  = last;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
      symbols_sent++;
   endtask

   // Full 34-symbol frame: leader, 32 data bits LSB first, unchecked stop.
   // A dirty frame has one symbol whose durations may each land on a window edge.
   task automatic send_frame(bit clean);
      logic [31:0] data;
      int          spoil;
      int          sel;
      sel = $urandom_range(9);
      data = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
      spoil = clean ? -1 : $urandom_range(32);
      for (int i = 0; i < FRAME_LEN; i++) begin
         int mk;
         int sp;
         if (i == 0) begin
            mk = tick_near(sb.timing[CSR_LEAD_MARK], i != spoil);
            sp = tick_near(sb.timing[CSR_LEAD_SPACE], i != spoil);
         end else if (i <= DATA_LAST && data[i-1]) begin
            mk = tick_near(sb.timing[CSR_ONE_MARK], i != spoil);
            sp = tick_near(sb.timing[CSR_ONE_SPACE], i != spoil);
         end else if (i <= DATA_LAST) begin
            mk = tick_near(sb.timing[CSR_ZERO_MARK], i != spoil);
            sp = tick_near(sb.timing[CSR_ZERO_SPACE], i != spoil);
         end else begin
            mk = noise_tick();
            sp = noise_tick();
         end
         send_symbol(mk, sp, i == FRAME_LEN - 1);
      end
   endtask

   task automatic send_repeat(bit clean);
      send_symbol(tick_near(REPEAT_MARK, clean), tick_near(sb.timing[CSR_REPEAT_SPACE], clean),
                  1'b0);
      send_symbol(noise_tick(), noise_tick(), 1'b1);
   endtask

   task automatic send_noise(int len);
      for (int i = 0; i < len; i++)
         send_symbol(noise_tick(), noise_tick(), i == len - 1);
   endtask

   // Mostly well-formed captures with random content; the rest short, odd,
   // near-frame or over-long (past the symbol count saturation) runs.
   task automatic send_random_capture();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45)
         send_frame(1'b1);
      else if (sel < 60)
         send_frame(1'b0);
      else if (sel < 75)
         send_repeat(1'b1);
      else if (sel < 80)
         send_repeat(1'b0);
      else if (sel < 92)
         send_noise($urandom_range(1, 6));
      else if (sel < 97)
         send_noise($urandom_range(30, 38));
      else
         send_noise($urandom_range(60, 80));
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      sb.write_reg(idx, val);
   endtask

   // Let the block empty: every result back, then settle more cycles for anything
   // still moving through the queue behind the last result.
   task automatic wait_drained(int settle);
      req_tvalid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Timing register sets, one per phase after the first.
   task automatic apply_setting(int phase);
      case (phase)
         1: begin
            // plausible but shifted timings
            csr_write(CSR_MARGIN,       TICK_W'($urandom_range(50, 400)));
            csr_write(CSR_LEAD_MARK,    TICK_W'($urandom_range(7000, 11000)));
            csr_write(CSR_LEAD_SPACE,   TICK_W'($urandom_range(3500, 5500)));
            csr_write(CSR_REPEAT_SPACE, TICK_W'($urandom_range(1800, 2700)));
            csr_write(CSR_ZERO_MARK,    TICK_W'($urandom_range(400, 700)));
            csr_write(CSR_ZERO_SPACE,   TICK_W'($urandom_range(400, 700)));
            csr_write(CSR_ONE_MARK,     TICK_W'($urandom_range(400, 700)));
            csr_write(CSR_ONE_SPACE,    TICK_W'($urandom_range(1400, 2000)));
         end
         2: begin
            // no tolerance: nothing may match; stray index must be dropped
            csr_write(CSR_MARGIN, 15'd0);
            csr_write(CSR_NONE,   15'd12345);
         end
         3: begin
            csr_write(CSR_MARGIN,       15'd32767);
            csr_write(CSR_LEAD_MARK,    15'd32767);
            csr_write(CSR_LEAD_SPACE,   15'd32767);
            csr_write(CSR_REPEAT_SPACE, 15'd32767);
            csr_write(CSR_ZERO_MARK,    15'd32767);
            csr_write(CSR_ZERO_SPACE,   15'd32767);
            csr_write(CSR_ONE_MARK,     15'd32767);
            csr_write(CSR_ONE_SPACE,    15'd32767);
         end
         4: begin
            // tiny windows near zero
            csr_write(CSR_MARGIN,       15'd2);
            csr_write(CSR_LEAD_MARK,    15'd0);
            csr_write(CSR_LEAD_SPACE,   15'd1);
            csr_write(CSR_REPEAT_SPACE, 15'd4);
            csr_write(CSR_ZERO_MARK,    15'd5);
            csr_write(CSR_ZERO_SPACE,   15'd3);
            csr_write(CSR_ONE_MARK,     15'd5);
            csr_write(CSR_ONE_SPACE,    15'd9);
         end
         default: begin
            csr_write(CSR_MARGIN,       RST_MARGIN);
            csr_write(CSR_LEAD_MARK,    RST_LEAD_MARK);
            csr_write(CSR_LEAD_SPACE,   RST_LEAD_SPACE);
            csr_write(CSR_REPEAT_SPACE, RST_REPEAT_SPACE);
            csr_write(CSR_ZERO_MARK,    RST_ZERO_MARK);
            csr_write(CSR_ZERO_SPACE,   RST_ZERO_SPACE);
            csr_write(CSR_ONE_MARK,     RST_ONE_MARK);
            csr_write(CSR_ONE_SPACE,    RST_ONE_SPACE);
         end
      endcase
      csr_we = 1'b0;
   endtask

   // Idle pattern per phase: none, sender idle, receiver stall, both.
   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 79; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 79; end
         default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
   endtask

   // Directed captures under reset timings (margin 200, repeat 9000/2250).
   task automatic send_directed();
      send_symbol(9000, 2250, 1'b0);          // nominal repeat code
      send_symbol(560, 560, 1'b1);
      send_symbol(9199, 2051, 1'b0);          // repeat at the inner window edges
      send_symbol(0, 0, 1'b1);
      send_symbol(8801, 2449, 1'b0);          // opposite inner edges
      send_symbol(32767, 32767, 1'b1);
      send_symbol(9200, 2250, 1'b0);          // mark on the outer edge: malformed
      send_symbol(32767, 32767, 1'b1);
      send_symbol(32767, 32767, 1'b1);        // single symbol, all ones
      send_symbol(0, 0, 1'b1);                // single symbol, all zeros
      send_symbol(9000, 4500, 1'b0);          // leader in a two-symbol capture
      send_symbol(560, 560, 1'b1);
      send_symbol(9000, 2250, 1'b0);          // three symbols: unknown length
      send_symbol(560, 560, 1'b0);
      send_symbol(560, 1690, 1'b1);
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained(10);
            apply_setting(phase);
         end
         set_idling(phase);
         if (phase == 0)
            send_directed();
         while (symbols_sent < (phase + 1) * PHASE_ITEMS)
            send_random_capture();
      end

      wait_drained(20);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
